@@ hw/rtl/rpn_stack_calculator_unit_macros.svh @@
// Assertion macros for the RPN stack calculator.
// Used by rpn_stack_calculator_unit only; no other dependencies.
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define RPN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rpn_pkg.sv @@
// Shared types and constants for the RPN stack calculator.
// No dependencies.
package rpn_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_MOD  = 3'd5,
    ACT_PRINT = 3'd6,
    ACT_CLEAR = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_B,
    S_WAIT_B,
    S_RD_A,
    S_WAIT_A,
    S_CALC,
    S_DIV_WAIT,
    S_WRITE,
    S_RD_TOP,
    S_WAIT_TOP,
    S_OUT
  } state_t;

  // Request to the divider: unsigned magnitudes; the caller applies signs.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -66'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/rpn_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on rpn_pkg for the request and response structs.
module rpn_div (
  input  logic             clk,
  input  logic             rst,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_rsp_t rsp
);

  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem[31:0], quo[63]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 7'd64;
        quo   <= req.dividend;
        dvs   <= req.divisor;
        rem   <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem[31:0]};

endmodule

@@ hw/rtl/rpn_mem.sv @@
// Stack store: single-port synchronous RAM with registered read data.
// No package dependencies.
module rpn_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/rpn_stack_calculator_unit.sv @@
// RPN stack calculator: one command in flight, stack in a synchronous RAM with
// registered read data. Divide and modulo wait on the 64-step bit-serial divider;
// a zero divisor, or a modulo divisor under 1.0 in magnitude, skips the divider.
// A new command is accepted only once the last result has been taken at the
// output. Reset sets the pointer to zero.
// Depends on rpn_pkg, rpn_mem, rpn_div and rpn_stack_calculator_unit_macros.svh.
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] top_value,
  output logic [1:0]         status,
  output logic [10:0]        depth
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  rpn_pkg::state_t  state, state_next;
  rpn_pkg::action_t act;
  logic [PW-1:0]    sp;
  logic signed [31:0] opv, b, a, res;
  logic             empty_hit, divz, full_hit, do_push;
  logic             b_neg, a_neg;
  logic signed [63:0] prod;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;

  rpn_pkg::div_req_t dreq;
  rpn_pkg::div_rsp_t drsp;

  rpn_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  rpn_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready  = (state == rpn_pkg::S_IDLE);
  assign out_valid = (state == rpn_pkg::S_OUT);
  assign depth     = 11'(sp);
  assign prod      = 64'(a) * 64'(b);

  logic [31:0] mag_a, mag_b, ia, ib;
  always_comb begin
    mag_a = a[31] ? 32'(-a) : a;
    mag_b = b[31] ? 32'(-b) : b;
    ia = {16'd0, mag_a[31:16]};
    ib = {16'd0, mag_b[31:16]};
  end

  // Divider request: divide uses |a|<<16 / |b|; modulo uses integer parts.
  always_comb begin
    dreq.start    = (state == rpn_pkg::S_CALC) &&
                    (act == rpn_pkg::ACT_DIV || act == rpn_pkg::ACT_MOD);
    dreq.dividend = (act == rpn_pkg::ACT_DIV) ? {16'd0, mag_a, 16'd0} : {32'd0, ia};
    dreq.divisor  = (act == rpn_pkg::ACT_DIV) ? mag_b : ib;
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_addr = AW'(sp - PW'(1));
    mem_wdata = res;
    case (state)
      rpn_pkg::S_IDLE:     if (in_valid) state_next = rpn_pkg::S_RD_B;
      rpn_pkg::S_RD_B: begin
        case (act)
          rpn_pkg::ACT_PUSH:  state_next = rpn_pkg::S_WRITE;
          rpn_pkg::ACT_PRINT, rpn_pkg::ACT_CLEAR: state_next = rpn_pkg::S_RD_TOP;
          default:            state_next = rpn_pkg::S_WAIT_B;
        endcase
      end
      rpn_pkg::S_WAIT_B:   state_next = rpn_pkg::S_RD_A;
      rpn_pkg::S_RD_A: begin
        if ((act == rpn_pkg::ACT_DIV || act == rpn_pkg::ACT_MOD) && b == 32'sd0)
          state_next = rpn_pkg::S_RD_TOP;
        else state_next = rpn_pkg::S_WAIT_A;
      end
      rpn_pkg::S_WAIT_A:   state_next = rpn_pkg::S_CALC;
      rpn_pkg::S_CALC: begin
        if (act == rpn_pkg::ACT_DIV || act == rpn_pkg::ACT_MOD) begin
          if (act == rpn_pkg::ACT_MOD && ib == 32'd0) state_next = rpn_pkg::S_RD_TOP;
          else state_next = rpn_pkg::S_DIV_WAIT;
        end else state_next = rpn_pkg::S_WRITE;
      end
      rpn_pkg::S_DIV_WAIT: if (drsp.done) state_next = rpn_pkg::S_WRITE;
      rpn_pkg::S_WRITE: begin
        mem_addr = AW'(sp);
        mem_we = do_push && (sp != FULL);
        state_next = rpn_pkg::S_RD_TOP;
      end
      rpn_pkg::S_RD_TOP:   state_next = rpn_pkg::S_WAIT_TOP;
      rpn_pkg::S_WAIT_TOP: state_next = rpn_pkg::S_OUT;
      rpn_pkg::S_OUT:      if (out_ready) state_next = rpn_pkg::S_IDLE;
      default:             state_next = rpn_pkg::S_IDLE;
    endcase
  end

  logic [63:0] q;
  logic signed [65:0] qs;
  logic signed [31:0] rm;
  always_comb begin
    q  = drsp.quotient;
    qs = (a_neg ^ b_neg) ? -$signed({2'b00, q}) : $signed({2'b00, q});
    rm = a_neg ? -$signed(drsp.remainder) : $signed(drsp.remainder);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::S_IDLE;
      sp <= '0;
    end else begin
      state <= state_next;
      case (state)
        rpn_pkg::S_IDLE: if (in_valid) begin
          act <= rpn_pkg::action_t'(action);
          opv <= operand_value;
          empty_hit <= 1'b0;
          divz <= 1'b0;
          full_hit <= 1'b0;
          do_push <= 1'b0;
        end
        rpn_pkg::S_RD_B: begin
          case (act)
            rpn_pkg::ACT_PUSH: begin
              res <= opv;
              do_push <= 1'b1;
              full_hit <= (sp == FULL);
            end
            rpn_pkg::ACT_PRINT: empty_hit <= (sp == '0);
            rpn_pkg::ACT_CLEAR: sp <= '0;
            default: begin
              if (sp == '0) empty_hit <= 1'b1;
              else sp <= sp - PW'(1);
            end
          endcase
        end
        rpn_pkg::S_WAIT_B: b <= (empty_hit) ? 32'sd0 : mem_rdata;
        rpn_pkg::S_RD_A: begin
          b_neg <= b[31];
          // A zero divisor leaves the left operand on the stack.
          if ((act == rpn_pkg::ACT_DIV || act == rpn_pkg::ACT_MOD) && b == 32'sd0)
            divz <= 1'b1;
          else if (sp == '0) empty_hit <= 1'b1;
          else sp <= sp - PW'(1);
        end
        rpn_pkg::S_WAIT_A: begin
          a <= (empty_hit) ? 32'sd0 : mem_rdata;
        end
        rpn_pkg::S_CALC: begin
          a_neg <= a[31];
          do_push <= 1'b1;
          case (act)
            rpn_pkg::ACT_ADD: res <= rpn_pkg::sat32(66'(a) + 66'(b));
            rpn_pkg::ACT_SUB: res <= rpn_pkg::sat32(66'(a) - 66'(b));
            rpn_pkg::ACT_MUL: res <= rpn_pkg::sat32(66'(prod >>> 16));
            rpn_pkg::ACT_MOD: if (ib == 32'd0) begin
              divz <= 1'b1;
              do_push <= 1'b0;
            end
            default: ;
          endcase
        end
        rpn_pkg::S_DIV_WAIT: if (drsp.done) begin
          if (act == rpn_pkg::ACT_DIV) res <= rpn_pkg::sat32(qs);
          else res <= {rm[15:0], 16'd0};
        end
        rpn_pkg::S_WRITE: if (do_push && sp != FULL) sp <= sp + PW'(1);
        rpn_pkg::S_WAIT_TOP: begin
          top_value <= (sp == '0) ? 32'sd0 : mem_rdata;
          if (empty_hit) status <= rpn_pkg::ST_EMPTY;
          else if (divz) status <= rpn_pkg::ST_DIVZ;
          else if (full_hit) status <= rpn_pkg::ST_FULL;
          else status <= rpn_pkg::ST_OK;
        end
        default: ;
      endcase
    end
  end

  `RPN_ASSERT_IMP(a_sp_range, clk, rst, 1'b1, sp <= FULL, "stack pointer beyond depth")
  `RPN_ASSERT_IMP(a_ready_excl, clk, rst, out_valid, !in_ready, "command taken while result pending")
  `RPN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(top_value), "result beat dropped")

endmodule

@@ verif/rpn_stack_calculator_unit_tb.sv @@
// Self-checking testbench for rpn_stack_calculator_unit: commands are driven through a queue,
// results are checked against an in-bench Q16.16 stack calculator model.
// Depends on rpn_pkg and the rpn_stack_calculator_unit RTL.
module rpn_stack_calculator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] operand_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [1:0]         status;
    logic [10:0]        depth;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] action = '0;
  logic signed [31:0] operand_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] top_value;
  logic [1:0] status;
  logic [10:0] depth;

  cmd_t pending_cmds[$];
  result_t expected_results[$];
  logic signed [31:0] calc_stack[DEPTH];
  int unsigned calc_sp;
  bit calc_empty_hit;
  int errors;
  int idle_cycles;
  int hold_off;

  rpn_stack_calculator_unit #(.STACK_DEPTH(DEPTH)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [31:0] saturate(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -66'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] calc_pop();
    if (calc_sp > 0) begin
      calc_sp--;
      return calc_stack[calc_sp];
    end
    calc_empty_hit = 1'b1;
    return 0;
  endfunction

  function automatic bit calc_push(input logic signed [31:0] v);
    if (calc_sp < DEPTH) begin
      calc_stack[calc_sp] = v;
      calc_sp++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one command to the bench stack and returns the expected result beat.
  function automatic result_t calc_step(input cmd_t c);
    logic signed [31:0] a, b;
    logic signed [63:0] p, ia, ib;
    logic [1:0] st;
    result_t r;
    st = rpn_pkg::ST_OK;
    calc_empty_hit = 1'b0;
    case (rpn_pkg::action_t'(c.action))
      rpn_pkg::ACT_PUSH: if (!calc_push(c.operand_value)) st = rpn_pkg::ST_FULL;
      rpn_pkg::ACT_ADD: begin
        b = calc_pop(); a = calc_pop();
        void'(calc_push(saturate(66'(a) + 66'(b))));
      end
      rpn_pkg::ACT_SUB: begin
        b = calc_pop(); a = calc_pop();
        void'(calc_push(saturate(66'(a) - 66'(b))));
      end
      rpn_pkg::ACT_MUL: begin
        b = calc_pop(); a = calc_pop();
        p = 64'(a) * 64'(b);
        void'(calc_push(saturate(66'(p >>> 16))));  // arithmetic shift floors
      end
      rpn_pkg::ACT_DIV: begin
        b = calc_pop();
        if (b != 0) begin
          a = calc_pop();
          void'(calc_push(saturate(66'((64'(a) * 64'sd65536) / 64'(b)))));
        end else st = rpn_pkg::ST_DIVZ;
      end
      rpn_pkg::ACT_MOD: begin
        b = calc_pop();
        if (b != 0) begin
          ib = 64'(b) / 64'sd65536;
          a = calc_pop();
          ia = 64'(a) / 64'sd65536;
          if (ib != 0) void'(calc_push(saturate(66'((ia % ib) * 64'sd65536))));
          else st = rpn_pkg::ST_DIVZ;
        end else st = rpn_pkg::ST_DIVZ;
      end
      rpn_pkg::ACT_PRINT: if (calc_sp == 0) calc_empty_hit = 1'b1;
      default: calc_sp = 0;
    endcase
    if (calc_empty_hit) st = rpn_pkg::ST_EMPTY;
    r.top_value = (calc_sp > 0) ? calc_stack[calc_sp - 1] : 32'sd0;
    r.status = st;
    r.depth = 11'(calc_sp);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      4: return $signed($urandom_range(0, 32'h7FFF)) - 32'sh4000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic cmd_t mk(input rpn_pkg::action_t act, input logic signed [31:0] v);
    cmd_t c;
    c.action = act;
    c.operand_value = v;
    return c;
  endfunction

  bit accepted_last = 1'b0;

  // Driver: waits a random gap (possibly none) between beats, holds each until accepted.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_last) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          action <= pending_cmds[0].action;
          operand_value <= pending_cmds[0].operand_value;
          in_valid <= 1'b1;
          void'(pending_cmds.pop_front());
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        end else in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    accepted_last <= 1'b0;
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(calc_step({action, operand_value}));
      accepted_last <= 1'b1;
    end
  end

  // Receiver: random stalls per beat, plus one long hold-off.
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid) recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (top_value !== exp_r.top_value) begin
            $error("top_value expected %0d actual %0d", exp_r.top_value, top_value);
            errors++;
          end
          if (status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status);
            errors++;
          end
          if (depth !== exp_r.depth) begin
            $error("depth expected %0d actual %0d", exp_r.depth, depth);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rpn_pkg::action_t act;
    int n, len;
    errors = 0;
    idle_cycles = 0;
    hold_off = 0;
    calc_sp = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty-stack cases, extremes, saturation, zero divisors, every command.
    pending_cmds.push_back(mk(rpn_pkg::ACT_PRINT, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_ADD, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_DIV, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sh7FFF_FFFF));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sh7FFF_FFFF));
    pending_cmds.push_back(mk(rpn_pkg::ACT_ADD, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sh8000_0000));
    pending_cmds.push_back(mk(rpn_pkg::ACT_MUL, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sh8000_0000));
    pending_cmds.push_back(mk(rpn_pkg::ACT_SUB, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_DIV, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sh0000_8000));
    pending_cmds.push_back(mk(rpn_pkg::ACT_MOD, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, -32'sd7 <<< 16));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sd3 <<< 16));
    pending_cmds.push_back(mk(rpn_pkg::ACT_MOD, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 32'sh0000_0001));
    pending_cmds.push_back(mk(rpn_pkg::ACT_DIV, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_MOD, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_CLEAR, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_PRINT, 0));
    pending_cmds.push_back(mk(rpn_pkg::ACT_MUL, 0));
    wait (pending_cmds.size() == 0);

    // Long receiver hold-off, then fill the stack to overflow, random commands and a clear.
    hold_off = 600;
    for (int i = 0; i < DEPTH + 3; i++) begin
      pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, rand_value()));
    end
    for (int i = 0; i < 40; i++) begin
      act = rpn_pkg::action_t'($urandom_range(1, 6));
      pending_cmds.push_back(mk(act, rand_value()));
    end
    pending_cmds.push_back(mk(rpn_pkg::ACT_CLEAR, 0));
    wait (pending_cmds.size() == 0);

    // Random: mostly short well-formed expressions, some noise.
    n = 0;
    while (n < 400) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(2, 5);
        for (int i = 0; i < len; i++) begin
          pending_cmds.push_back(mk(rpn_pkg::ACT_PUSH, rand_value()));
        end
        for (int i = 1; i < len; i++) begin
          pending_cmds.push_back(mk(rpn_pkg::action_t'($urandom_range(1, 5)),
                                    $signed($urandom())));
        end
        if ($urandom_range(0, 1)) begin
          pending_cmds.push_back(mk(rpn_pkg::ACT_PRINT, $signed($urandom())));
        end
        n += 2 * len;
      end else begin
        pending_cmds.push_back(mk(rpn_pkg::action_t'($urandom_range(0, 7)), rand_value()));
        n++;
      end
      wait (pending_cmds.size() < 8);
    end
    wait (pending_cmds.size() == 0 && !in_valid);

    fork
      begin
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
      end
    join_any
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
